>>> rtl/core/hshs_pkg.sv
`timescale 1ns / 1ps

package hshs_pkg;

   // Request kinds carried on the input tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_ESTOP = 2'd2;

   // Homing phases
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_FAST_START = 3'd1;
   localparam logic [2:0] PH_FAST       = 3'd2;
   localparam logic [2:0] PH_SLOW       = 3'd3;
   localparam logic [2:0] PH_BACKOFF    = 3'd4;
   localparam logic [2:0] PH_DONE       = 3'd5;

   // Drive commands carried on the result tuser
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_JOG  = 3'd1;
   localparam logic [2:0] CMD_STOP = 3'd2;
   localparam logic [2:0] CMD_MOVE = 3'd3;
   localparam logic [2:0] CMD_ZERO = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_AXIS_ENABLED  = 3'd0;
   localparam logic [2:0] CSR_FAST_SPEED    = 3'd1;
   localparam logic [2:0] CSR_SLOW_SPEED    = 3'd2;
   localparam logic [2:0] CSR_FAST_PHASE_MS = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_MS    = 3'd4;
   localparam logic [2:0] CSR_BACKOFF_STEPS = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [19:0] FAST_SPEED_RST    = 20'd10000;
   localparam logic [19:0] SLOW_SPEED_RST    = 20'd1000;
   localparam logic [15:0] FAST_PHASE_MS_RST = 16'd2000;
   localparam logic [31:0] TIMEOUT_MS_RST    = 32'd10000;

   typedef struct packed {
      logic               axis_enabled;
      logic [19:0]        fast_speed;
      logic [19:0]        slow_speed;
      logic [15:0]        fast_phase_ms;
      logic [31:0]        timeout_ms;
      logic signed [23:0] backoff_steps;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic        drive_asserted;
      logic        steps_done;
   } item_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [23:0] command_value;
      logic               start_accepted;
      logic               homed;
      logic               homing_active;
      logic [2:0]         homing_phase;
      logic               moving;
   } result_type;

endpackage

>>> rtl/core/hard_stop_homing_sequencer.sv
`timescale 1ns / 1ps

// Flow: an accepted word lands in the input register, and its result word is registered in
// the result register once that register is free or being drained; rsp_tvalid then rises.
// Throughput: one word per cycle unless rsp_tready stalls; the input and result registers
// form a two-deep pipe; step logic updates the homing state as each word passes through.
// Reset: synchronous, active high; clears both valid flags, the homing state to idle and
// not homed, and loads every configuration register with its default.

module hard_stop_homing_sequencer
   import hshs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // now_ms[31:0], drive_asserted[32], steps_done[33]
   input  logic [1:0]            req_tuser,  // req_type[1:0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // command_value[23:0], start_accepted[24],
                                             // homed[25], homing_active[26],
                                             // homing_phase[29:27], moving[30]
   output logic [2:0]            rsp_tuser,  // command[2:0]
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type out_res_ff;
   logic       out_valid_ff, out_valid_in;
   result_type step_res;
   logic       req_fire;
   logic       out_load;

   hshs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // move a word on when the result register is free or being drained this cycle
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (out_load ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_load ? 1'b1 : ((out_valid_ff && rsp_tready) ? 1'b0 : out_valid_ff);

   hshs_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (out_load),
      .item  (in_item_ff),
      .res   (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.req_type       <= req_tuser;
         in_item_ff.now_ms         <= req_tdata[31:0];
         in_item_ff.drive_asserted <= req_tdata[32];
         in_item_ff.steps_done     <= req_tdata[33];
      end
      if (out_load) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.command;
   assign rsp_tdata  = {1'b0,
                        out_res_ff.moving,
                        out_res_ff.homing_phase,
                        out_res_ff.homing_active,
                        out_res_ff.homed,
                        out_res_ff.start_accepted,
                        out_res_ff.command_value};

endmodule

>>> rtl/core/hshs_csr.sv
`timescale 1ns / 1ps

module hshs_csr
   import hshs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // hold unless the addressed register is written; other indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_AXIS_ENABLED:  cfg_in.axis_enabled  = csr_wdata[0];
            CSR_FAST_SPEED:    cfg_in.fast_speed    = csr_wdata[19:0];
            CSR_SLOW_SPEED:    cfg_in.slow_speed    = csr_wdata[19:0];
            CSR_FAST_PHASE_MS: cfg_in.fast_phase_ms = csr_wdata[15:0];
            CSR_TIMEOUT_MS:    cfg_in.timeout_ms    = csr_wdata[31:0];
            CSR_BACKOFF_STEPS: cfg_in.backoff_steps = signed'(csr_wdata[23:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_enabled  <= 1'b0;
         cfg_ff.fast_speed    <= FAST_SPEED_RST;
         cfg_ff.slow_speed    <= SLOW_SPEED_RST;
         cfg_ff.fast_phase_ms <= FAST_PHASE_MS_RST;
         cfg_ff.timeout_ms    <= TIMEOUT_MS_RST;
         cfg_ff.backoff_steps <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/hshs_core.sv
`timescale 1ns / 1ps

module hshs_core
   import hshs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output result_type res
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic        homed_ff, homed_in;
   logic        failed_ff, failed_in;
   logic [31:0] elapsed;
   logic        fast_over;
   logic        slow_over;

   // elapsed time wraps with the timestamp
   assign elapsed   = item.now_ms - phase_start_ff;
   assign fast_over = elapsed >= {16'd0, cfg.fast_phase_ms};
   assign slow_over = elapsed >= cfg.timeout_ms;

   always_comb begin
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      homed_in       = homed_ff;
      failed_in      = failed_ff;
      res            = '0;
      res.command    = CMD_NONE;
      case (item.req_type)
         REQ_START: begin
            if (cfg.axis_enabled && (phase_ff == PH_IDLE)) begin
               homed_in           = 1'b0;
               phase_start_in     = item.now_ms;
               phase_in           = PH_FAST_START;
               res.start_accepted = 1'b1;
            end
         end
         REQ_ESTOP: begin
            res.command = CMD_STOP;
            phase_in    = PH_IDLE;
            failed_in   = 1'b0;
         end
         REQ_TICK: begin
            if (cfg.axis_enabled) begin
               case (phase_ff)
                  PH_FAST_START: begin
                     res.command       = CMD_JOG;
                     res.command_value = signed'(24'd0 - {4'd0, cfg.fast_speed});
                     phase_start_in    = item.now_ms;
                     phase_in          = PH_FAST;
                  end
                  PH_FAST: begin
                     if (fast_over) begin
                        res.command       = CMD_JOG;
                        res.command_value = signed'(24'd0 - {4'd0, cfg.slow_speed});
                        phase_start_in    = item.now_ms;
                        phase_in          = PH_SLOW;
                     end
                  end
                  PH_SLOW: begin
                     if (item.drive_asserted) begin
                        res.command = CMD_STOP;
                        phase_in    = PH_BACKOFF;
                     end else if (slow_over) begin
                        failed_in = 1'b1;
                        phase_in  = PH_DONE;
                     end
                  end
                  PH_BACKOFF: begin
                     res.command       = CMD_MOVE;
                     res.command_value = cfg.backoff_steps;
                     failed_in         = 1'b0;
                     phase_in          = PH_DONE;
                  end
                  PH_DONE: begin
                     if (failed_ff) begin
                        failed_in = 1'b0;
                        phase_in  = PH_IDLE;
                     end else if (item.steps_done) begin
                        res.command = CMD_ZERO;
                        homed_in    = 1'b1;
                        phase_in    = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         default: begin
            res.command = CMD_NONE;
         end
      endcase
      res.homed         = homed_in;
      res.homing_active = (phase_in != PH_IDLE);
      res.homing_phase  = phase_in;
      res.moving        = ~item.steps_done;
   end

   // advance only when a word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_start_ff <= '0;
         homed_ff       <= 1'b0;
         failed_ff      <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         homed_ff       <= homed_in;
         failed_ff      <= failed_in;
      end
   end

`ifndef SYNTHESIS
   a_estop_idles: assert property (@(posedge clock) disable iff (reset)
      (step && (item.req_type == REQ_ESTOP)) |=> (phase_ff == PH_IDLE) && !failed_ff)
      else $error("emergency stop did not return to idle");

   a_homed_on_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(homed_ff) |-> ($past(step) && ($past(res.command) == CMD_ZERO)))
      else $error("homed set without a zero-position command");

   a_failed_in_done: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (phase_ff == PH_DONE))
      else $error("failure pending outside the done phase");

   a_start_enters_fast: assert property (@(posedge clock) disable iff (reset)
      (step && res.start_accepted) |=> (phase_ff == PH_FAST_START) && !homed_ff)
      else $error("accepted start did not enter fast start");
`endif

endmodule

>>> test/homing_check_pkg.sv
`timescale 1ns / 1ps

package homing_check_pkg;

   import hshs_pkg::*;

   // Request kind that the sequencer has no use for
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   class homing_scoreboard;

      cfg_type     cfg;
      logic [2:0]  phase;
      logic [31:0] phase_start;
      logic        homed_flag;
      logic        failed_pending;
      result_type  pending_q[$];
      int          fail_count;

      function new();
         cfg.axis_enabled  = 1'b0;
         cfg.fast_speed    = FAST_SPEED_RST;
         cfg.slow_speed    = SLOW_SPEED_RST;
         cfg.fast_phase_ms = FAST_PHASE_MS_RST;
         cfg.timeout_ms    = TIMEOUT_MS_RST;
         cfg.backoff_steps = '0;
         phase             = PH_IDLE;
         phase_start       = '0;
         homed_flag        = 1'b0;
         failed_pending    = 1'b0;
         fail_count        = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_AXIS_ENABLED:  cfg.axis_enabled  = value[0];
            CSR_FAST_SPEED:    cfg.fast_speed    = value[19:0];
            CSR_SLOW_SPEED:    cfg.slow_speed    = value[19:0];
            CSR_FAST_PHASE_MS: cfg.fast_phase_ms = value[15:0];
            CSR_TIMEOUT_MS:    cfg.timeout_ms    = value;
            CSR_BACKOFF_STEPS: cfg.backoff_steps = value[23:0];
            default: ;
         endcase
      endfunction

      // Advance the homing state by one request word and queue the drive word it yields
      function void note_request(item_type it);
         result_type  r;
         logic [31:0] elapsed;
         elapsed = it.now_ms - phase_start;
         r = '0;
         r.command = CMD_NONE;
         case (it.req_type)
            REQ_START: begin
               if (cfg.axis_enabled && phase == PH_IDLE) begin
                  homed_flag       = 1'b0;
                  phase_start      = it.now_ms;
                  phase            = PH_FAST_START;
                  r.start_accepted = 1'b1;
               end
            end
            REQ_ESTOP: begin
               r.command      = CMD_STOP;
               phase          = PH_IDLE;
               failed_pending = 1'b0;
            end
            REQ_TICK: begin
               if (cfg.axis_enabled) begin
                  case (phase)
                     PH_FAST_START: begin
                        r.command       = CMD_JOG;
                        r.command_value = 24'd0 - {4'd0, cfg.fast_speed};
                        phase_start     = it.now_ms;
                        phase           = PH_FAST;
                     end
                     PH_FAST: begin
                        if (elapsed >= {16'd0, cfg.fast_phase_ms}) begin
                           r.command       = CMD_JOG;
                           r.command_value = 24'd0 - {4'd0, cfg.slow_speed};
                           phase_start     = it.now_ms;
                           phase           = PH_SLOW;
                        end
                     end
                     PH_SLOW: begin
                        if (it.drive_asserted) begin
                           r.command = CMD_STOP;
                           phase     = PH_BACKOFF;
                        end else if (elapsed >= cfg.timeout_ms) begin
                           failed_pending = 1'b1;
                           phase          = PH_DONE;
                        end
                     end
                     PH_BACKOFF: begin
                        r.command       = CMD_MOVE;
                        r.command_value = cfg.backoff_steps;
                        failed_pending  = 1'b0;
                        phase           = PH_DONE;
                     end
                     PH_DONE: begin
                        if (failed_pending) begin
                           failed_pending = 1'b0;
                           phase          = PH_IDLE;
                        end else if (it.steps_done) begin
                           r.command  = CMD_ZERO;
                           homed_flag = 1'b1;
                           phase      = PH_IDLE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         r.homed         = homed_flag;
         r.homing_active = (phase != PH_IDLE);
         r.homing_phase  = phase;
         r.moving        = !it.steps_done;
         pending_q.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] exp_v, logic [31:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_result(result_type got);
         result_type exp_r;
         if (pending_q.size() == 0) begin
            $error("drive word with no request behind it");
            fail_count++;
            return;
         end
         exp_r = pending_q.pop_front();
         compare("command", exp_r.command, got.command);
         compare("command_value", exp_r.command_value, got.command_value);
         compare("start_accepted", exp_r.start_accepted, got.start_accepted);
         compare("homed", exp_r.homed, got.homed);
         compare("homing_active", exp_r.homing_active, got.homing_active);
         compare("homing_phase", exp_r.homing_phase, got.homing_phase);
         compare("moving", exp_r.moving, got.moving);
      endfunction

   endclass

endpackage

>>> test/hard_stop_homing_sequencer_tb.sv
`timescale 1ns / 1ps

module hard_stop_homing_sequencer_tb;

   import hshs_pkg::*;
   import homing_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 13;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [39:0]           req_tdata;   // now_ms[31:0], drive_asserted[32], steps_done[33]
   logic [1:0]            req_tuser;   // req_type[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;   // command_value, start_accepted, homed,
                                       // homing_active, homing_phase, moving
   logic [2:0]            rsp_tuser;   // command[2:0]
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   homing_scoreboard sb;
   bit               idle_on = 1'b1;  // random gaps on both sides when set
   logic [31:0]      ms_now;
   int               cycle_count = 0;

   hard_stop_homing_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon the run if the handshakes stop making progress
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: check each accepted drive word, then pick the next ready at random.
   // Values read here are those from before this edge, since everything else updates
   // through nonblocking assignments.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.command        = rsp_tuser;
         got.command_value  = rsp_tdata[23:0];
         got.start_accepted = rsp_tdata[24];
         got.homed          = rsp_tdata[25];
         got.homing_active  = rsp_tdata[26];
         got.homing_phase   = rsp_tdata[29:27];
         got.moving         = rsp_tdata[30];
         sb.check_result(got);
      end
      rsp_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
   end

   function automatic item_type word(logic [1:0] kind, logic [31:0] now,
                                     logic asserted, logic done);
      item_type it;
      it.req_type       = kind;
      it.now_ms         = now;
      it.drive_asserted = asserted;
      it.steps_done     = done;
      return it;
   endfunction

   // Offer one request word, with a random gap in front, and hold it until taken.
   // Valid stays high after the handshake so back-to-back words follow without a gap.
   task automatic send_word(item_type it);
      int gap;
      gap = 0;
      while (idle_on && $urandom_range(99) < IDLE_PCT)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.req_type;
      req_tdata  <= {6'd0, it.steps_done, it.drive_asserted, it.now_ms};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
   endtask

   // Drop valid and hold off until every drive word owed has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(logic [2:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Write the full register set back to back; only call with the block drained
   task automatic configure(cfg_type c);
      put_reg(CSR_AXIS_ENABLED, {31'd0, c.axis_enabled});
      put_reg(CSR_FAST_SPEED, {12'd0, c.fast_speed});
      put_reg(CSR_SLOW_SPEED, {12'd0, c.slow_speed});
      put_reg(CSR_FAST_PHASE_MS, {16'd0, c.fast_phase_ms});
      put_reg(CSR_TIMEOUT_MS, c.timeout_ms);
      put_reg(CSR_BACKOFF_STEPS, {8'd0, c.backoff_steps});
      csr_we <= 1'b0;
   endtask

   initial begin
      cfg_type    setting;
      item_type   it;
      logic [1:0] kind;
      logic [31:0] step;
      int         roll;
      int         words;
      int         quota;

      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_TICK;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Axis still disabled after reset: only the emergency stop does anything
      send_word(word(REQ_TICK, 32'd0, 1'b0, 1'b1));
      send_word(word(REQ_START, 32'd1, 1'b0, 1'b1));
      send_word(word(REQ_ESTOP, 32'd2, 1'b1, 1'b0));
      send_word(word(REQ_RESERVED, 32'd3, 1'b1, 1'b1));
      drain();

      // Extremes: top fast speed, zero slow speed, no fast phase, instant timeout,
      // most negative back-off; timestamps straddle the 32-bit wrap
      setting.axis_enabled  = 1'b1;
      setting.fast_speed    = 20'd1000000;
      setting.slow_speed    = 20'd0;
      setting.fast_phase_ms = 16'd0;
      setting.timeout_ms    = 32'd0;
      setting.backoff_steps = 24'sh800000;
      configure(setting);
      send_word(word(REQ_START, 32'hFFFF_FFF0, 1'b0, 1'b1));
      send_word(word(REQ_START, 32'hFFFF_FFF1, 1'b0, 1'b1));   // not idle: refused
      send_word(word(REQ_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0));
      send_word(word(REQ_TICK, 32'h0000_0002, 1'b0, 1'b0));
      send_word(word(REQ_TICK, 32'h0000_0003, 1'b1, 1'b0));    // hard stop reached
      send_word(word(REQ_TICK, 32'h0000_0004, 1'b0, 1'b0));    // back-off move
      send_word(word(REQ_TICK, 32'h0000_0005, 1'b0, 1'b0));    // steps outstanding
      send_word(word(REQ_TICK, 32'h0000_0006, 1'b0, 1'b1));    // zero and homed
      // Second run ends by timeout; homed drops on the accepted start
      send_word(word(REQ_START, 32'h0000_0010, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'h0000_0011, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'h0000_0011, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'h0000_0011, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'h0000_0012, 1'b0, 1'b1));    // failed: back to idle
      drain();

      // Opposite extremes: zero fast speed, top slow speed, longest fast phase,
      // longest timeout, most positive back-off
      setting.fast_speed    = 20'd0;
      setting.slow_speed    = 20'd1000000;
      setting.fast_phase_ms = 16'hFFFF;
      setting.timeout_ms    = 32'hFFFF_FFFF;
      setting.backoff_steps = 24'sh7FFFFF;
      configure(setting);
      send_word(word(REQ_START, 32'd100, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'd100, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'd100 + 32'd65534, 1'b0, 1'b1));  // one short
      send_word(word(REQ_TICK, 32'd100 + 32'd65535, 1'b0, 1'b1));
      send_word(word(REQ_TICK, 32'd100 + 32'd65534, 1'b0, 1'b1));  // elapsed wraps to max
      send_word(word(REQ_ESTOP, 32'd7, 1'b0, 1'b1));              // clears the failure
      send_word(word(REQ_START, 32'd8, 1'b0, 1'b0));
      send_word(word(REQ_ESTOP, 32'd9, 1'b0, 1'b0));
      drain();

      // Random part: several register settings, each with mostly well-formed homing
      // runs; the sender and receiver run without gaps in one of them
      ms_now = $urandom;
      for (int s = 0; s < 8; s++) begin
         setting.axis_enabled = (s != 5);
         case ($urandom_range(3))
            0: setting.fast_speed = 20'd0;
            1: setting.fast_speed = 20'd1000000;
            default: setting.fast_speed = 20'($urandom_range(1000000));
         endcase
         case ($urandom_range(3))
            0: setting.slow_speed = 20'd0;
            1: setting.slow_speed = 20'd1000000;
            default: setting.slow_speed = 20'($urandom_range(1000000));
         endcase
         setting.fast_phase_ms = (s == 6) ? 16'hFFFF : 16'($urandom_range(12));
         case ($urandom_range(4))
            0: setting.timeout_ms = 32'd0;
            1: setting.timeout_ms = 32'hFFFF_FFFF;
            2: setting.timeout_ms = $urandom;
            default: setting.timeout_ms = $urandom_range(30);
         endcase
         setting.backoff_steps = 24'($urandom);
         drain();
         configure(setting);
         idle_on = (s != 2);
         quota   = setting.axis_enabled ? 110 : 30;
         words   = 0;
         while (words < quota) begin
            roll = $urandom_range(99);
            case ($urandom_range(15))
               0: step = $urandom;
               1, 2, 3: step = 32'd0;
               default: step = $urandom_range(10);
            endcase
            ms_now = ms_now + step;
            // Favour starts when idle and ticks once a run is under way
            if (sb.phase == PH_IDLE)
               kind = (roll < 60) ? REQ_START : (roll < 88) ? REQ_TICK :
                      (roll < 96) ? REQ_ESTOP : REQ_RESERVED;
            else
               kind = (roll < 88) ? REQ_TICK : (roll < 93) ? REQ_START :
                      (roll < 97) ? REQ_ESTOP : REQ_RESERVED;
            it = word(kind, ms_now, $urandom_range(99) < 25, 1'($urandom_range(1)));
            send_word(it);
            if (kind != REQ_RESERVED)
               words++;
         end
      end
      idle_on = 1'b1;

      // Hold until the last drive word is back, then let the block settle before the verdict
      drain();
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
